>>> hw/rtl/cmt_pkg.sv
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared types and codes for the counted multiset table.
// ----------------------------------------------------------------------------
package cmt_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 16;
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

	typedef enum logic [1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_QUERY  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_ABSENT  = 2'd1,
		ST_FULL    = 2'd2,
		ST_LIMIT   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SCAN,
		PH_APPLY,
		PH_OUT
	} phase_t;

	// token passed from cell to cell
	typedef struct packed {
		logic              hit;
		logic              free_seen;
		logic              any;
		logic signed [VALUE_W-1:0] lo;
		logic signed [VALUE_W-1:0] hi;
	} token_t;

	// per-pass command broadcast to every cell
	typedef struct packed {
		logic              scan;
		logic              apply;
		logic [1:0]        func;
		logic [VALUE_W-1:0] value;
	} cmd_t;

endpackage

>>> hw/rtl/counted_multiset_table.sv
// ----------------------------------------------------------------------------
// counted_multiset_table
// Bag of signed 32-bit values held in a chain of CAPACITY slot cells.
// ----------------------------------------------------------------------------
// A token walks the cell chain one cell per cycle, twice per item: once to match
// the key and once to update and take min/max. A new item is accepted only while
// the table is idle, after the previous result has gone into the result register.
// A result register frees the chain; it stalls only while the register is full.
// Reset clears all counts, used bits and totals; no clearing pass is needed.
module counted_multiset_table #(
	parameter int CAPACITY = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [1:0]   func,
	input  logic signed [31:0] value,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [1:0]   status,
	output logic         present,
	output logic [15:0]  occurrences,
	output logic [21:0]  total_items,
	output logic [6:0]   distinct_items,
	output logic signed [32:0] spread
);
	import cmt_pkg::*;

	localparam int IW = $clog2(CAPACITY);

	phase_t state_q, state_d;
	logic [IW-1:0] idx_q;
	cmd_t cmd_q;
	token_t tok_q;
	token_t cell_out [CAPACITY];
	logic [COUNT_W-1:0] cnt [CAPACITY];
	logic hit_q;
	logic [COUNT_W-1:0] occ_q;
	logic [22:0] total_q;
	logic [6:0]  dist_q;
	logic [1:0]  status_q;
	logic        last;
	token_t      cur;
	logic        lim_add;
	logic [COUNT_W-1:0] occ_after;
	logic signed [32:0] spread_now;
	logic        res_load;
	logic        rv_q;
	logic [1:0]  res_status_q;
	logic        res_present_q;
	logic [COUNT_W-1:0] res_occ_q;
	logic [21:0] res_total_q;
	logic [6:0]  res_dist_q;
	logic signed [32:0] res_spread_q;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			cmt_cell u_cell (
				.clk(clk), .arst_n(arst_n),
				.cmd(cmd_q),
				.active(idx_q == IW'(g)),
				.tok_in(tok_q),
				.tok_out(cell_out[g]),
				.count(cnt[g])
			);
		end
	endgenerate

	// token moves one cell per cycle; only the addressed cell's output is taken
	always_comb begin
		cur = tok_q;
		for (int i = 0; i < CAPACITY; i++)
			if (idx_q == IW'(i)) cur = cell_out[i];
	end

	assign last = (idx_q == IW'(CAPACITY - 1));
	assign in_ready  = (state_q == PH_IDLE);
	assign res_load  = (state_q == PH_OUT) && (!rv_q || out_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			PH_IDLE:  if (in_valid) state_d = PH_SCAN;
			PH_SCAN:  if (last) state_d = PH_APPLY;
			PH_APPLY: if (last) state_d = PH_OUT;
			PH_OUT:   if (res_load) state_d = PH_IDLE;
			default:  state_d = PH_IDLE;
		endcase
	end

	assign lim_add  = (cmd_q.func == FUNC_ADD) && hit_q && (occ_q == COUNT_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= PH_IDLE;
			idx_q    <= '0;
			cmd_q    <= '0;
			tok_q    <= '0;
			occ_q    <= '0;
			total_q  <= '0;
			dist_q   <= '0;
			status_q <= ST_DONE;
			hit_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				PH_IDLE: begin
					if (in_valid) begin
						cmd_q.scan  <= 1'b1;
						cmd_q.apply <= 1'b0;
						cmd_q.func  <= func;
						cmd_q.value <= value;
						idx_q <= '0;
						tok_q <= '0;
						occ_q <= '0;
					end
				end
				PH_SCAN: begin
					if (cnt[idx_q] != '0) occ_q <= cnt[idx_q];
					if (last) begin
						hit_q <= cur.hit;
						cmd_q.scan  <= 1'b0;
						cmd_q.apply <= 1'b1;
						idx_q <= '0;
						// hit rides along so no free slot is taken for a held value
						tok_q <= '{hit: cur.hit, default: '0};
					end else begin
						tok_q <= cur;
						idx_q <= idx_q + 1'b1;
					end
				end
				PH_APPLY: begin
					tok_q <= cur;
					if (last) begin
						cmd_q.apply <= 1'b0;
						idx_q <= '0;
						if (lim_add) begin
							status_q <= ST_LIMIT;
						end else if (cmd_q.func == FUNC_ADD && !hit_q && !cur.free_seen) begin
							status_q <= ST_FULL;
						end else if (cmd_q.func == FUNC_REMOVE && !hit_q) begin
							status_q <= ST_ABSENT;
						end else begin
							status_q <= ST_DONE;
						end
						if (cmd_q.func == FUNC_ADD && !lim_add && (hit_q || cur.free_seen)) begin
							total_q <= total_q + 1'b1;
							if (!hit_q) dist_q <= dist_q + 1'b1;
						end else if (cmd_q.func == FUNC_REMOVE && hit_q) begin
							total_q <= total_q - 1'b1;
							if (occ_q == COUNT_W'(1)) dist_q <= dist_q - 1'b1;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				PH_OUT: ;
				default: ;
			endcase
		end
	end

	// result occurrences after the operation
	always_comb begin
		occ_after = occ_q;
		if (status_q == ST_DONE) begin
			if (cmd_q.func == FUNC_ADD) occ_after = occ_q + 1'b1;
			else if (cmd_q.func == FUNC_REMOVE) occ_after = occ_q - 1'b1;
		end else if (status_q != ST_LIMIT) begin
			occ_after = '0;
		end
	end

	assign spread_now = tok_q.any ? (33'(tok_q.hi) - 33'(tok_q.lo)) : -33'sd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q          <= 1'b0;
			res_status_q  <= ST_DONE;
			res_present_q <= 1'b0;
			res_occ_q     <= '0;
			res_total_q   <= '0;
			res_dist_q    <= '0;
			res_spread_q  <= '0;
		end else begin
			if (res_load) begin
				rv_q          <= 1'b1;
				res_status_q  <= status_q;
				res_present_q <= (occ_after != '0);
				res_occ_q     <= occ_after;
				res_total_q   <= total_q[21:0];
				res_dist_q    <= dist_q;
				res_spread_q  <= spread_now;
			end else if (out_ready) begin
				rv_q <= 1'b0;
			end
		end
	end

	assign out_valid      = rv_q;
	assign status         = res_status_q;
	assign occurrences    = res_occ_q;
	assign present        = res_present_q;
	assign total_items    = res_total_q;
	assign distinct_items = res_dist_q;
	assign spread         = res_spread_q;

	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_LIMIT |-> present && occurrences == COUNT_LIMIT)
		else $error("limit result without full count");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped");
	a_absent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ABSENT |-> !present) else $error("absent but present");

endmodule

>>> hw/rtl/cmt_cell.sv
// ----------------------------------------------------------------------------
// cmt_cell
// One table slot: holds value, count and used bit. During a scan pass it
// compares against the key; during an apply pass it updates itself and folds
// its value into the min/max token handed to the next cell.
// ----------------------------------------------------------------------------
module cmt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  cmt_pkg::cmd_t     cmd,
	input  logic              active,
	input  cmt_pkg::token_t   tok_in,
	output cmt_pkg::token_t   tok_out,
	output logic [cmt_pkg::COUNT_W-1:0] count
);
	import cmt_pkg::*;

	logic [VALUE_W-1:0] value_q;
	logic [COUNT_W-1:0] count_q;
	logic               used_q;
	logic               match;
	logic               take_free;
	logic               n_used;
	logic [COUNT_W-1:0] n_count;
	logic signed [VALUE_W-1:0] sv;

	assign match     = used_q && (value_q == cmd.value);
	assign take_free = !used_q && !tok_in.free_seen && !tok_in.hit
		&& (cmd.func == FUNC_ADD);

	always_comb begin
		n_used  = used_q;
		n_count = count_q;
		if (cmd.apply && active) begin
			if (cmd.func == FUNC_ADD) begin
				if (match && count_q != COUNT_LIMIT) begin
					n_count = count_q + 1'b1;
				end else if (take_free) begin
					n_used  = 1'b1;
					n_count = COUNT_W'(1);
				end
			end else if (cmd.func == FUNC_REMOVE && match) begin
				if (count_q > COUNT_W'(1)) begin
					n_count = count_q - 1'b1;
				end else begin
					n_used  = 1'b0;
					n_count = '0;
				end
			end
		end
	end

	assign sv = (cmd.apply && take_free) ? cmd.value : value_q;

	always_comb begin
		tok_out = tok_in;
		if (cmd.scan) begin
			tok_out.hit = tok_in.hit | match;
		end else if (cmd.apply) begin
			if (!used_q) tok_out.free_seen = 1'b1;
			if (n_used) begin
				if (!tok_in.any || sv < tok_in.lo) tok_out.lo = sv;
				if (!tok_in.any || sv > tok_in.hi) tok_out.hi = sv;
				tok_out.any = 1'b1;
			end
		end
	end

	assign count = (match || (cmd.apply && take_free)) ? n_count : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			count_q <= '0;
		end else begin
			used_q  <= n_used;
			count_q <= n_count;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && active && take_free) value_q <= cmd.value;
	end

endmodule
